[rtl/core/two_class_priority_ordered_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Priority table assertion macros
// Shared concurrent assertion forms for the priority table checker.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_ORDERED_TABLE_TOP_DEFINES_SVH
`define TWO_CLASS_PRIORITY_ORDERED_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTAB_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTAB_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ptab_pkg.sv]
// ----------------------------------------------------------------------------
// Priority table package
// Operation codes, status codes and cell control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptab_pkg;

  localparam int DEPTH_DEFAULT         = 16;
  localparam int TAG_BITS_DEFAULT      = 16;
  localparam int PRIORITY_BITS_DEFAULT = 8;

  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_MARK   = 3'd2;
  localparam logic [2:0] KIND_DROP   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_MARK   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occupied;
    logic     at_or_after;
    logic     is_tail;
  } cell_ctrl_t;

endpackage

[rtl/core/ptab_if.sv]
// ----------------------------------------------------------------------------
// Priority table channels
// Request and response word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptab_in_if #(
  parameter int POS_BITS      = 4,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               kind;
  logic [TAG_BITS-1:0]      entry_tag;
  logic [PRIORITY_BITS-1:0] entry_priority;
  logic                     entry_done;
  logic [POS_BITS-1:0]      position;

  modport source (
    output valid, kind, entry_tag, entry_priority, entry_done, position,
    input  ready
  );
  modport sink (
    input  valid, kind, entry_tag, entry_priority, entry_done, position,
    output ready
  );
endinterface

interface ptab_out_if #(
  parameter int COUNT_BITS    = 5,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 8
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [TAG_BITS-1:0]      read_tag;
  logic [PRIORITY_BITS-1:0] read_priority;
  logic                     read_done;
  logic [COUNT_BITS-1:0]    entry_count;

  modport source (
    output valid, status, read_tag, read_priority, read_done, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, read_tag, read_priority, read_done, entry_count,
    output ready
  );
endinterface

[rtl/core/two_class_priority_ordered_table_top.sv]
// A table of up to DEPTH entries kept in a chain of cells: open entries first in
// ascending priority, then done entries in the order they were marked. Each
// request word (add, remove, mark done, drop done, read) is carried out in the
// cycle it is accepted, since every cell compares and shifts in parallel with
// its neighbors, and its response word is registered in the output buffer. A
// two-word response buffer keeps the request side open while a response
// waits, so one request per cycle is sustained whenever responses are taken.
// There is no startup sweep; the table is empty out of reset.
// ----------------------------------------------------------------------------
// Priority table top level
// Ordered two-class entry table built as a shifting chain of cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_class_priority_ordered_table_top #(
  parameter int DEPTH         = ptab_pkg::DEPTH_DEFAULT,
  parameter int TAG_BITS      = ptab_pkg::TAG_BITS_DEFAULT,
  parameter int PRIORITY_BITS = ptab_pkg::PRIORITY_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  ptab_in_if.sink      req,
  ptab_out_if.source   rsp
);
  import ptab_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = 2 + TAG_BITS + PRIORITY_BITS + 1 + CW;

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            drop_count;
  logic [CW-1:0]            pos_ext;
  logic                     pos_ok;
  logic                     full;
  logic                     accept;
  cell_op_t                 op;
  logic [1:0]               status;
  logic [TAG_BITS-1:0]      rd_tag;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic                     rd_done;
  logic [TAG_BITS-1:0]      sel_tag;
  logic [PRIORITY_BITS-1:0] sel_prio;
  logic                     sel_done;
  logic [RW-1:0]            rsp_word;

  cell_ctrl_t               ctrl [DEPTH];
  logic [TAG_BITS-1:0]      tag  [DEPTH];
  logic [PRIORITY_BITS-1:0] prio [DEPTH];
  logic [DEPTH-1:0]         done;
  logic [DEPTH-1:0]         flag;
  logic [DEPTH-1:0]         open;
  logic [DEPTH:0]           open_ext;
  logic [DEPTH-1:0]         pos_hit;

  assign accept  = req.valid && req.ready;
  assign pos_ext = CW'(req.position);
  assign pos_ok  = pos_ext < count;
  assign full    = count == CW'(DEPTH);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign pos_hit[i]          = req.position == PW'(i);
    assign ctrl[i].op          = accept ? op : CELL_HOLD;
    assign ctrl[i].occupied    = CW'(i) < count;
    assign ctrl[i].at_or_after = CW'(i) >= pos_ext;
    assign ctrl[i].is_tail     = CW'(i + 1) == count;

    ptab_cell #(
      .TAG_BITS      (TAG_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl[i]),
      .new_tag    (req.entry_tag),
      .new_prio   (req.entry_priority),
      .new_done   (req.entry_done),
      .left_flag  ((i == 0) ? 1'b0 : flag[(i == 0) ? 0 : i - 1]),
      .left_tag   (tag[(i == 0) ? 0 : i - 1]),
      .left_prio  (prio[(i == 0) ? 0 : i - 1]),
      .left_done  (done[(i == 0) ? 0 : i - 1]),
      .right_tag  (tag[(i == DEPTH - 1) ? i : i + 1]),
      .right_prio (prio[(i == DEPTH - 1) ? i : i + 1]),
      .right_done (done[(i == DEPTH - 1) ? i : i + 1]),
      .sel_tag    (sel_tag),
      .sel_prio   (sel_prio),
      .tag        (tag[i]),
      .prio       (prio[i]),
      .done       (done[i]),
      .flag       (flag[i]),
      .open       (open[i])
    );
  end

  always_comb begin
    sel_tag  = '0;
    sel_prio = '0;
    sel_done = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_tag  = sel_tag | (tag[i] & {TAG_BITS{pos_hit[i]}});
      sel_prio = sel_prio | (prio[i] & {PRIORITY_BITS{pos_hit[i]}});
      sel_done = sel_done | (done[i] & pos_hit[i]);
    end
  end

  // Open entries form a prefix, so the kept count is where that prefix ends.
  assign open_ext = {1'b0, open};

  always_comb begin
    drop_count = '0;
    for (int i = 1; i <= DEPTH; i++) begin
      if (open_ext[i - 1] && !open_ext[i]) begin
        drop_count = CW'(i);
      end
    end
  end

  always_comb begin
    op         = CELL_HOLD;
    status     = ST_OK;
    count_next = count;
    rd_tag     = '0;
    rd_prio    = '0;
    rd_done    = 1'b0;
    unique case (req.kind)
      KIND_ADD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op         = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          op         = CELL_REMOVE;
          count_next = count - CW'(1);
        end
      end
      KIND_MARK: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          op = CELL_MARK;
        end
      end
      KIND_DROP: begin
        count_next = drop_count;
      end
      KIND_READ: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          rd_tag  = sel_tag;
          rd_prio = sel_prio;
          rd_done = sel_done;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  assign rsp_word = {status, rd_tag, rd_prio, rd_done, count_next};

  ptab_outbuf #(
    .WIDTH (RW)
  ) u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (rsp_word),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  ({rsp.status, rsp.read_tag, rsp.read_priority, rsp.read_done,
                 rsp.entry_count})
  );

endmodule

[rtl/core/ptab_cell.sv]
// ----------------------------------------------------------------------------
// Priority table cell
// Holds one table entry and shifts with its neighbors on insert and removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptab_cell #(
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                     clk,
  input  ptab_pkg::cell_ctrl_t     ctrl,
  input  logic [TAG_BITS-1:0]      new_tag,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic                     new_done,
  input  logic                     left_flag,
  input  logic [TAG_BITS-1:0]      left_tag,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic                     left_done,
  input  logic [TAG_BITS-1:0]      right_tag,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic                     right_done,
  input  logic [TAG_BITS-1:0]      sel_tag,
  input  logic [PRIORITY_BITS-1:0] sel_prio,
  output logic [TAG_BITS-1:0]      tag,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     done,
  output logic                     flag,
  output logic                     open
);
  import ptab_pkg::*;

  // The flag marks entries that a new entry goes ahead of. Because the table
  // stays ordered, the flags along the chain are a run of zeros then ones.
  assign flag = !ctrl.occupied || (!new_done && (done || (new_prio < prio)));
  assign open = ctrl.occupied && !done;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (flag && !left_flag) begin
          tag  <= new_tag;
          prio <= new_prio;
          done <= new_done;
        end else if (left_flag) begin
          tag  <= left_tag;
          prio <= left_prio;
          done <= left_done;
        end
      end
      CELL_REMOVE: begin
        if (ctrl.at_or_after) begin
          tag  <= right_tag;
          prio <= right_prio;
          done <= right_done;
        end
      end
      CELL_MARK: begin
        if (ctrl.is_tail) begin
          tag  <= sel_tag;
          prio <= sel_prio;
          done <= 1'b1;
        end else if (ctrl.at_or_after) begin
          tag  <= right_tag;
          prio <= right_prio;
          done <= right_done;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/ptab_outbuf.sv]
// ----------------------------------------------------------------------------
// Priority table response buffer
// Output register with a skid stage so a request is taken while a word waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptab_outbuf #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             pop;
  logic             push;

  assign in_ready = !skid_valid;
  assign pop      = out_valid && out_ready;
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

endmodule

[rtl/core/ptab_chk.sv]
// ----------------------------------------------------------------------------
// Priority table checker
// Port-level checks on response ordering, buffering and result contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_class_priority_ordered_table_top_defines.svh"

module ptab_chk #(
  parameter int DEPTH         = ptab_pkg::DEPTH_DEFAULT,
  parameter int TAG_BITS      = ptab_pkg::TAG_BITS_DEFAULT,
  parameter int PRIORITY_BITS = ptab_pkg::PRIORITY_BITS_DEFAULT
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [1:0]                 rsp_status,
  input logic [TAG_BITS-1:0]        rsp_read_tag,
  input logic [PRIORITY_BITS-1:0]   rsp_read_priority,
  input logic                       rsp_read_done,
  input logic [$clog2(DEPTH+1)-1:0] rsp_entry_count
);
  import ptab_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0] pending;
  logic       req_take;
  logic       rsp_take;

  assign req_take = req_valid && req_ready;
  assign rsp_take = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_take} - {1'b0, rsp_take};
    end
  end

  `PTAB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "response word dropped while stalled")
  `PTAB_ASSERT_IMP(a_rsp_owed, clk, rst, rsp_valid, pending != 2'd0, "response word without a request word")
  `PTAB_ASSERT_IMP(a_buf_limit, clk, rst, pending == 2'd2, !req_ready, "request taken with two responses held")
  `PTAB_ASSERT_IMP(a_full_count, clk, rst, rsp_valid && (rsp_status == ST_FULL), rsp_entry_count == CW'(DEPTH), "full status with table not full")
  `PTAB_ASSERT_IMP(a_err_zero, clk, rst, rsp_valid && (rsp_status != ST_OK), (rsp_read_tag == '0) && (rsp_read_priority == '0) && !rsp_read_done, "read fields set on an error")

endmodule

bind two_class_priority_ordered_table_top ptab_chk #(
  .DEPTH         (DEPTH),
  .TAG_BITS      (TAG_BITS),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_ptab_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_read_tag      (rsp.read_tag),
  .rsp_read_priority (rsp.read_priority),
  .rsp_read_done     (rsp.read_done),
  .rsp_entry_count   (rsp.entry_count)
);
